[hw/rtl/sust_pkg.sv]
// Shared types and constants for the sorted unique set table.
// Holds the request/response beat structs, status codes and cell control.
// No dependencies.
package sust_pkg;

	// Table geometry
	localparam int DEPTH   = 64;
	localparam int KEY_W   = 64;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int POS_W   = 7;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [KEY_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		status_t           status;
		logic [POS_W-1:0]  count_after;
	} rsp_t;

	// Broadcast from the sequencer to every cell
	typedef struct packed {
		logic              cmp;
		logic              ins;
		logic              rem;
		logic [KEY_W-1:0]  key;
	} cell_ctrl_t;

endpackage

[hw/rtl/sust_cell.sv]
// One slot of the sorted table: holds an entry and its compare flags.
// Shifts with its neighbors on insert and remove. Depends on sust_pkg.
module sust_cell import sust_pkg::*; (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic              occ,
	input  logic              left_lt,
	input  logic [KEY_W-1:0]  left_entry,
	input  logic [KEY_W-1:0]  right_entry,
	output logic [KEY_W-1:0]  entry,
	output logic              lt,
	output logic              eq
);

	logic [KEY_W-1:0] entry_q;
	logic             lt_q;
	logic             eq_q;

	// Compare phase: flags only count for occupied slots
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			lt_q <= occ && (entry_q < ctrl.key);
			eq_q <= occ && (entry_q == ctrl.key);
		end
	end

	// Update phase: slots at or above the insert/remove point move
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt_q) begin
			entry_q <= left_lt ? ctrl.key : left_entry;
		end else if (ctrl.rem && !lt_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

[hw/rtl/sorted_unique_set_table.sv]
// Top level of the sorted unique set table: sequencer, count and cell row.
// Depends on sust_pkg and sust_cell.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------
//  request  | start / busy       | req  (kind, value)
//  response | done (1-cycle)     | rsp  (position, status, count_after)
//
// Each request passes through a compare cycle in which every cell checks
// its entry against the key, then an update cycle in which the cells shift
// and the response beat is registered. busy is high only in the compare
// cycle, so a new request can be taken on the update edge.
// Reset clears the sequencer and the count; entries are not cleared.
// The receiver cannot stall; done is high for exactly one cycle per request.
module sorted_unique_set_table import sust_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  req_t  req,
	output logic  busy,
	output logic  done,
	output rsp_t  rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	rsp_t              rsp_q;

	cell_ctrl_t        ctrl;
	logic [DEPTH-1:0]  occ;
	logic [DEPTH-1:0]  lt_v;
	logic [DEPTH-1:0]  eq_v;
	logic [DEPTH-1:0]  left_lt_v;
	logic [KEY_W-1:0]  entry_v [DEPTH];

	logic              accept;
	logic              hit;
	logic              full;
	logic [CNT_W-1:0]  pos;
	status_t           status;
	logic              do_ins;
	logic              do_rem;
	logic [CNT_W-1:0]  count_nxt;

	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  state_q <= start ? S_CMP : S_IDLE;
				S_CMP:   state_q <= S_UPD;
				S_UPD:   state_q <= start ? S_CMP : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			key_q  <= req.value;
		end
	end

	// Cell control broadcast
	assign ctrl.cmp = (state_q == S_CMP);
	assign ctrl.ins = do_ins;
	assign ctrl.rem = do_rem;
	assign ctrl.key = key_q;

	// Cell row
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		assign occ[gi] = (count_q > CNT_W'(gi));
		if (gi == 0) begin : g_first
			assign left_lt_v[gi] = 1'b1;
		end else begin : g_rest
			assign left_lt_v[gi] = lt_v[gi-1];
		end
		sust_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ[gi]),
			.left_lt     (left_lt_v[gi]),
			.left_entry  (gi == 0 ? key_q : entry_v[(gi == 0) ? 0 : gi-1]),
			.right_entry (gi == DEPTH-1 ? entry_v[gi] : entry_v[(gi == DEPTH-1) ? gi : gi+1]),
			.entry       (entry_v[gi]),
			.lt          (lt_v[gi]),
			.eq          (eq_v[gi])
		);
	end

	// Position: the lt flags form a thermometer; encode its edge
	always_comb begin
		pos = '0;
		if (&lt_v) begin
			pos = CNT_W'(DEPTH);
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (left_lt_v[i] && !lt_v[i]) begin
				pos = pos | CNT_W'(i);
			end
		end
	end

	// Decision in the update cycle
	assign hit  = |eq_v;
	assign full = (count_q == CNT_W'(DEPTH));

	always_comb begin
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		count_nxt = count_q;
		status    = ST_ABSENT;
		if (kind_q == KIND_INSERT) begin
			priority if (hit) begin
				status = ST_PRESENT;
			end else if (full) begin
				status = ST_FULL;
			end else begin
				status    = ST_INSERTED;
				do_ins    = (state_q == S_UPD);
				count_nxt = count_q + CNT_W'(1);
			end
		end else begin
			if (hit) begin
				status    = ST_REMOVED;
				do_rem    = (state_q == S_UPD);
				count_nxt = count_q - CNT_W'(1);
			end
		end
	end

	// Count and response beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_UPD);
			if (state_q == S_UPD) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			rsp_q.position    <= POS_W'(pos);
			rsp_q.status      <= status;
			rsp_q.count_after <= POS_W'(count_nxt);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_UPD))
		else $error("done without an update cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	a_count_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.count_after == POS_W'(count_q)))
		else $error("count_after disagrees with stored count");

	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_CMP))
		else $error("accepted request did not enter compare");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |-> !full && !hit)
		else $error("insert into full table or duplicate");
`endif

endmodule
